// ----- src/mmfl_pkg.sv -----
// ----------------------------------------------------------------------------
// mmfl_pkg
// Shared types and constants of the min/max/first/last line decimator.
// ----------------------------------------------------------------------------
package mmfl_pkg;

  // Default width of the logical index kept inside the block
  localparam int INDEX_WIDTH_DEF = 16;

  // Number of kept points per bucket: first, minimum, maximum, last
  localparam int NUM_SLOTS = 4;

  // Request codes of an input word
  localparam logic REQ_POINT = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CONFLATE = 2'd0,
    CFG_RATIO    = 2'd1,
    CFG_FROM     = 2'd2,
    CFG_TO       = 2'd3
  } cfg_idx_t;

  // Input word
  typedef struct packed {
    logic               req_type;
    logic [31:0]        point_time;
    logic signed [31:0] point_value;
    logic [31:0]        point_color;
    logic [15:0]        point_index;
    logic               index_found;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [31:0]        out_time;
    logic signed [31:0] out_value;
    logic [31:0]        out_color;
    logic [15:0]        out_index;
    logic               last_of_run;
  } out_word_t;

  // Configuration register set
  typedef struct packed {
    logic        conflate_enable;
    logic [15:0] bucket_ratio;
    logic [15:0] range_from;
    logic [15:0] range_to;
  } cfg_t;

  // One point as held in the kept slots and the emit buffer
  typedef struct packed {
    logic [31:0]        ptime;
    logic signed [31:0] pvalue;
    logic [31:0]        pcolor;
    logic [15:0]        pindex;
  } pt_t;

  // Load of the emit buffer: packed, index-ordered points and their count
  typedef struct packed {
    pt_t [NUM_SLOTS-1:0] ent;
    logic [2:0]          cnt;
  } emit_load_t;

endpackage

// ----- src/min_max_first_last_decimator_core.sv -----
// ----------------------------------------------------------------------------
// min_max_first_last_decimator_core
// Line point decimator keeping first, minimum, maximum and last per bucket.
// ----------------------------------------------------------------------------
// A word is taken into the input register in any cycle the register is empty
// or its word moves on; a word that causes no result moves on the next cycle,
// a pass-through point too while the emit buffer is free, so such streams run
// at one word per cycle while the output does not stall. A word that closes
// a bucket loads up to four index-ordered results into the emit buffer, which
// hands out one result per cycle unless the output stalls; the next word with
// results waits until it drains. Words reach it through the input register.
module min_max_first_last_decimator_core #(
  parameter int INDEX_WIDTH = mmfl_pkg::INDEX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mmfl_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mmfl_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  mmfl_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import mmfl_pkg::*;

  cfg_t                   cfg_r;
  logic                   s1_valid;
  logic                   s1_req;
  logic                   s1_keep;
  pt_t                    s1_pt;
  logic [INDEX_WIDTH-1:0] s1_ix;
  logic [INDEX_WIDTH-1:0] s1_bucket;
  logic                   produces;
  logic                   emit_free;
  logic                   go;
  logic                   emit_ld;
  emit_load_t             load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.conflate_enable <= 1'b0;
      cfg_r.bucket_ratio    <= 16'd0;
      cfg_r.range_from      <= 16'd0;
      cfg_r.range_to        <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONFLATE: cfg_r.conflate_enable <= cfg_wdata[0];
        CFG_RATIO:    cfg_r.bucket_ratio    <= cfg_wdata;
        CFG_FROM:     cfg_r.range_from      <= cfg_wdata;
        CFG_TO:       cfg_r.range_to        <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // the staged word moves on unless its results find the buffer busy
  assign go      = s1_valid && (!produces || emit_free);
  assign emit_ld = go && produces;

  mmfl_in_stage #(.IW(INDEX_WIDTH)) u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .go        (go),
    .s1_valid  (s1_valid),
    .s1_req    (s1_req),
    .s1_keep   (s1_keep),
    .s1_pt     (s1_pt),
    .s1_ix     (s1_ix),
    .s1_bucket (s1_bucket)
  );

  mmfl_bucket #(.IW(INDEX_WIDTH)) u_bucket (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .s1_valid  (s1_valid),
    .s1_req    (s1_req),
    .s1_keep   (s1_keep),
    .s1_pt     (s1_pt),
    .s1_ix     (s1_ix),
    .s1_bucket (s1_bucket),
    .go        (go),
    .produces  (produces),
    .load      (load)
  );

  mmfl_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_en     (emit_ld),
    .load      (load),
    .free      (emit_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a new run is loaded only over an empty or draining buffer
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_ld |-> (!out_valid || (out_data.last_of_run && !out_stall)))
    else $error("emit buffer overwritten");

  // a run is not broken before its last word
  a_run_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_of_run) |=> out_valid)
    else $error("result run broken");

  // the input only stalls while a word waits in the stage
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && produces))
    else $error("input stalled without a waiting word");

endmodule

// ----- src/mmfl_in_stage.sv -----
// ----------------------------------------------------------------------------
// mmfl_in_stage
// Input register: captures a word, masks the index, checks the window and
// registers the bucket number (index times ratio, upper bits).
// ----------------------------------------------------------------------------
module mmfl_in_stage #(
  parameter int IW = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mmfl_pkg::in_word_t in_data,
  input  mmfl_pkg::cfg_t     cfg,
  input  logic               go,
  output logic               s1_valid,
  output logic               s1_req,
  output logic               s1_keep,
  output mmfl_pkg::pt_t      s1_pt,
  output logic [IW-1:0]      s1_ix,
  output logic [IW-1:0]      s1_bucket
);
  import mmfl_pkg::*;

  localparam int CW = (IW > 16) ? IW : 16;
  localparam int PW = IW + 16;

  logic          valid_r;
  logic          req_r;
  logic          keep_r;
  pt_t           pt_r;
  logic [IW-1:0] ix_r;
  logic [IW-1:0] bucket_r;

  logic          accept;
  logic [IW-1:0] ix_w;
  logic          keep_w;
  logic [PW-1:0] prod_w;

  assign in_stall = valid_r && !go;
  assign accept   = in_valid && !in_stall;

  // index mask, window check, bucket product
  always_comb begin
    ix_w   = IW'(in_data.point_index);
    keep_w = in_data.index_found &&
             (CW'(ix_w) >= CW'(cfg.range_from)) &&
             (CW'(ix_w) <= CW'(cfg.range_to));
    prod_w = PW'(ix_w) * PW'(cfg.bucket_ratio);
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (go) begin
      valid_r <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r       <= in_data.req_type;
      keep_r      <= keep_w;
      pt_r.ptime  <= in_data.point_time;
      pt_r.pvalue <= in_data.point_value;
      pt_r.pcolor <= in_data.point_color;
      pt_r.pindex <= 16'(ix_w);
      ix_r        <= ix_w;
      bucket_r    <= prod_w[PW-1:16];
    end
  end

  assign s1_valid  = valid_r;
  assign s1_req    = req_r;
  assign s1_keep   = keep_r;
  assign s1_pt     = pt_r;
  assign s1_ix     = ix_r;
  assign s1_bucket = bucket_r;

endmodule

// ----- src/mmfl_bucket.sv -----
// ----------------------------------------------------------------------------
// mmfl_bucket
// Bucket state: the four kept points, the open flag and the current bucket.
// Builds the index-ordered, de-duplicated flush list or the pass-through word.
// ----------------------------------------------------------------------------
module mmfl_bucket #(
  parameter int IW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mmfl_pkg::cfg_t       cfg,
  input  logic                 s1_valid,
  input  logic                 s1_req,
  input  logic                 s1_keep,
  input  mmfl_pkg::pt_t        s1_pt,
  input  logic [IW-1:0]        s1_ix,
  input  logic [IW-1:0]        s1_bucket,
  input  logic                 go,
  output logic                 produces,
  output mmfl_pkg::emit_load_t load
);
  import mmfl_pkg::*;

  pt_t           kept_pt_r [NUM_SLOTS];
  logic [IW-1:0] kept_ix_r [NUM_SLOTS];
  logic          open_r;
  logic [IW-1:0] cur_r;

  logic          new_bucket;
  logic          lt_min;
  logic          gt_max;
  logic          emit_s [NUM_SLOTS];
  logic [1:0]    rank_s [NUM_SLOTS];
  logic [2:0]    flush_cnt;

  // bucket change and min / max tests
  always_comb begin
    new_bucket = !open_r || (s1_bucket != cur_r);
    lt_min     = $signed(s1_pt.pvalue) < $signed(kept_pt_r[1].pvalue);
    gt_max     = $signed(s1_pt.pvalue) > $signed(kept_pt_r[2].pvalue);
  end

  // results caused by the word in the stage
  always_comb begin
    if (s1_req == REQ_FLUSH) begin
      produces = open_r;
    end else begin
      produces = s1_keep && (!cfg.conflate_enable || (open_r && new_bucket));
    end
  end

  // skip later slots that repeat an index, rank the rest by index
  always_comb begin
    logic [2:0] acc;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      emit_s[s] = 1'b1;
      for (int j = 0; j < s; j++) begin
        if (kept_ix_r[j] == kept_ix_r[s]) begin
          emit_s[s] = 1'b0;
        end
      end
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      acc = 3'd0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (emit_s[j] && (kept_ix_r[j] < kept_ix_r[s])) begin
          acc = acc + 3'd1;
        end
      end
      rank_s[s] = acc[1:0];
    end
    flush_cnt = 3'd0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (emit_s[s]) begin
        flush_cnt = flush_cnt + 3'd1;
      end
    end
  end

  // emit buffer load: flush list, or one pass-through word
  always_comb begin
    load = '0;
    if ((s1_req == REQ_FLUSH) || cfg.conflate_enable) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (emit_s[s] && (rank_s[s] == 2'(k))) begin
            load.ent[k] = kept_pt_r[s];
          end
        end
      end
      load.cnt = flush_cnt;
    end else begin
      load.ent[0] = s1_pt;
      load.cnt    = 3'd1;
    end
  end

  // open flag and current bucket
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      cur_r  <= '0;
    end else if (go && s1_valid) begin
      if (s1_req == REQ_FLUSH) begin
        open_r <= 1'b0;
      end else if (s1_keep && cfg.conflate_enable && new_bucket) begin
        open_r <= 1'b1;
        cur_r  <= s1_bucket;
      end
    end
  end

  // kept points: reseed on a new bucket, else track min, max and last
  always_ff @(posedge clk) begin
    if (go && s1_valid && (s1_req == REQ_POINT) && s1_keep && cfg.conflate_enable) begin
      if (new_bucket) begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          kept_pt_r[s] <= s1_pt;
          kept_ix_r[s] <= s1_ix;
        end
      end else begin
        if (lt_min) begin
          kept_pt_r[1] <= s1_pt;
          kept_ix_r[1] <= s1_ix;
        end
        if (gt_max) begin
          kept_pt_r[2] <= s1_pt;
          kept_ix_r[2] <= s1_ix;
        end
        kept_pt_r[3] <= s1_pt;
        kept_ix_r[3] <= s1_ix;
      end
    end
  end

endmodule

// ----- src/mmfl_emit.sv -----
// ----------------------------------------------------------------------------
// mmfl_emit
// Emit buffer: holds up to four results, hands out one a cycle unless stalled.
// ----------------------------------------------------------------------------
module mmfl_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ld_en,
  input  mmfl_pkg::emit_load_t load,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mmfl_pkg::out_word_t  out_data
);
  import mmfl_pkg::*;

  pt_t        ent_r [NUM_SLOTS];
  logic [1:0] pos_r;
  logic [2:0] cnt_r;
  logic       take;

  assign out_valid = (cnt_r != 3'd0);
  assign take      = out_valid && !out_stall;
  // free when empty or the last word leaves this cycle
  assign free      = !out_valid || (take && (cnt_r == 3'd1));

  // read pointer and words left
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
      cnt_r <= 3'd0;
    end else if (ld_en) begin
      pos_r <= 2'd0;
      cnt_r <= load.cnt;
    end else if (take) begin
      pos_r <= pos_r + 2'd1;
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // buffer words
  always_ff @(posedge clk) begin
    if (ld_en) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        ent_r[k] <= load.ent[k];
      end
    end
  end

  // result word
  always_comb begin
    out_data.out_time    = ent_r[pos_r].ptime;
    out_data.out_value   = ent_r[pos_r].pvalue;
    out_data.out_color   = ent_r[pos_r].pcolor;
    out_data.out_index   = ent_r[pos_r].pindex;
    out_data.last_of_run = (cnt_r == 3'd1);
  end

endmodule
